[rtl/raster_format_sniffer_unit_defines.svh]
// Assertion macros shared by the raster format sniffer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef RASTER_FORMAT_SNIFFER_UNIT_DEFINES_SVH
`define RASTER_FORMAT_SNIFFER_UNIT_DEFINES_SVH

// Checks that an implication holds at every clock edge out of reset.
`define RFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition in one cycle implies another in the next.
`define RFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rfs_pkg.sv]
// Package for the raster format sniffer: result codes, limits, the result type and brand checks.
// Depends on nothing.
`default_nettype none
package rfs_pkg;
    localparam int unsigned MaxProbeBytes = 4096;
    localparam int unsigned CountW = $clog2(MaxProbeBytes + 1);
    localparam int unsigned ReqW = 13;

    typedef enum logic [3:0] {
        FMT_UNKNOWN = 4'd0, FMT_JPEG = 4'd1, FMT_PNG = 4'd2, FMT_GIF = 4'd3,
        FMT_BMP = 4'd4, FMT_WEBP = 4'd5, FMT_TIFF = 4'd6, FMT_ICO = 4'd7,
        FMT_PSD = 4'd8, FMT_JPEGXL = 4'd9, FMT_AVIF = 4'd10, FMT_HEIF = 4'd11
    } t_format;

    typedef enum logic [1:0] {
        ST_MATCHED = 2'd0, ST_UNSUPPORTED = 2'd1, ST_TRUNCATED = 2'd2, ST_MALFORMED = 2'd3
    } t_status;

    typedef struct packed {
        t_format               format_code;
        t_status               probe_status;
        logic [ReqW-1:0]       bytes_required;
    } t_result;

    function automatic logic brand_is_hevc(input logic [31:0] b);
        return b == 32'h68656963 || b == 32'h68656978 || b == 32'h68657663 ||
               b == 32'h68657678 || b == 32'h6865696D || b == 32'h68656973 ||
               b == 32'h6865766D || b == 32'h68657673;
    endfunction

    function automatic logic brand_is_avif(input logic [31:0] b);
        return b == 32'h61766966 || b == 32'h61766973;
    endfunction
endpackage
`default_nettype wire

[rtl/rfs_stream_if.sv]
// Valid/ready channel interfaces for the raster format sniffer.
// Depends on rfs_pkg.
`default_nettype none
interface rfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface rfs_out_if;
    logic                     valid;
    logic                     ready;
    logic [3:0]               format_code;
    logic [1:0]               probe_status;
    logic [rfs_pkg::ReqW-1:0] bytes_required;
    modport source (output valid, format_code, probe_status, bytes_required, input ready);
    modport sink (input valid, format_code, probe_status, bytes_required, output ready);
endinterface
`default_nettype wire

[rtl/rfs_classify.sv]
// Combinational magic-number classifier over the held header bytes and brand flags.
// Depends on rfs_pkg.
`default_nettype none
module rfs_classify (
    input  wire logic [7:0]                  i_win [16],
    input  wire logic [rfs_pkg::CountW-1:0]  i_count,
    input  wire logic [31:0]                 i_major,
    input  wire logic                        i_hevc,
    input  wire logic                        i_avif,
    input  wire logic                        i_still,
    output rfs_pkg::t_result                 o_result
);
    logic [7:0] sig_jxl [12];
    logic [7:0] sig_png [8];
    logic [7:0] w [16];

    assign sig_jxl = '{8'h00, 8'h00, 8'h00, 8'h0C, 8'h4A, 8'h58, 8'h4C, 8'h20,
                       8'h0D, 8'h0A, 8'h87, 8'h0A};
    assign sig_png = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};

    // Bytes not yet received read as zero.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w[i] = (i_count > rfs_pkg::CountW'(i)) ? i_win[i] : 8'h00;
        end
    end

    function automatic logic bm(input logic [rfs_pkg::CountW-1:0] n, input int pos,
                                input logic [7:0] got, input logic [7:0] want);
        return (n <= rfs_pkg::CountW'(pos)) || (got == want);
    endfunction

    function automatic rfs_pkg::t_result mk(input rfs_pkg::t_format f,
                                            input rfs_pkg::t_status s,
                                            input int unsigned r);
        rfs_pkg::t_result x;
        x.format_code = f;
        x.probe_status = s;
        x.bytes_required = rfs_pkg::ReqW'(r);
        return x;
    endfunction

    logic [12:0] n;
    logic m_jxl, m_psd, m_jpg, m_png, m_g7, m_g9, m_ico, m_lc, m_bc, m_lb, m_bb;
    logic m_riff, m_webp, m_ftyp4;
    logic [31:0] be0, be8, be12, le2, le6, le10, le4;
    logic [63:0] box, minimum;
    logic ext;
    logic bok;

    always_comb begin
        n = 13'(i_count);
        m_jxl = 1'b1;
        for (int i = 0; i < 12; i++) m_jxl &= bm(i_count, i, w[i], sig_jxl[i]);
        m_png = 1'b1;
        for (int i = 0; i < 8; i++) m_png &= bm(i_count, i, w[i], sig_png[i]);
        m_psd = bm(i_count, 0, w[0], 8'h38) && bm(i_count, 1, w[1], 8'h42) &&
                bm(i_count, 2, w[2], 8'h50) && bm(i_count, 3, w[3], 8'h53);
        m_jpg = bm(i_count, 0, w[0], 8'hFF) && bm(i_count, 1, w[1], 8'hD8) &&
                bm(i_count, 2, w[2], 8'hFF);
        m_g7 = bm(i_count, 0, w[0], 8'h47) && bm(i_count, 1, w[1], 8'h49) &&
               bm(i_count, 2, w[2], 8'h46) && bm(i_count, 3, w[3], 8'h38) &&
               bm(i_count, 4, w[4], 8'h37) && bm(i_count, 5, w[5], 8'h61);
        m_g9 = bm(i_count, 0, w[0], 8'h47) && bm(i_count, 1, w[1], 8'h49) &&
               bm(i_count, 2, w[2], 8'h46) && bm(i_count, 3, w[3], 8'h38) &&
               bm(i_count, 4, w[4], 8'h39) && bm(i_count, 5, w[5], 8'h61);
        m_ico = bm(i_count, 0, w[0], 8'h00) && bm(i_count, 1, w[1], 8'h00) &&
                bm(i_count, 2, w[2], 8'h01) && bm(i_count, 3, w[3], 8'h00);
        m_lc = bm(i_count, 0, w[0], 8'h49) && bm(i_count, 1, w[1], 8'h49) &&
               bm(i_count, 2, w[2], 8'h2A) && bm(i_count, 3, w[3], 8'h00);
        m_bc = bm(i_count, 0, w[0], 8'h4D) && bm(i_count, 1, w[1], 8'h4D) &&
               bm(i_count, 2, w[2], 8'h00) && bm(i_count, 3, w[3], 8'h2A);
        m_lb = bm(i_count, 0, w[0], 8'h49) && bm(i_count, 1, w[1], 8'h49) &&
               bm(i_count, 2, w[2], 8'h2B) && bm(i_count, 3, w[3], 8'h00);
        m_bb = bm(i_count, 0, w[0], 8'h4D) && bm(i_count, 1, w[1], 8'h4D) &&
               bm(i_count, 2, w[2], 8'h00) && bm(i_count, 3, w[3], 8'h2B);
        m_riff = bm(i_count, 0, w[0], 8'h52) && bm(i_count, 1, w[1], 8'h49) &&
                 bm(i_count, 2, w[2], 8'h46) && bm(i_count, 3, w[3], 8'h46);
        m_webp = bm(i_count, 8, w[8], 8'h57) && bm(i_count, 9, w[9], 8'h45) &&
                 bm(i_count, 10, w[10], 8'h42) && bm(i_count, 11, w[11], 8'h50);
        m_ftyp4 = bm(i_count, 4, w[4], 8'h66) && bm(i_count, 5, w[5], 8'h74) &&
                  bm(i_count, 6, w[6], 8'h79) && bm(i_count, 7, w[7], 8'h70);
        be0 = {w[0], w[1], w[2], w[3]};
        be8 = {w[8], w[9], w[10], w[11]};
        be12 = {w[12], w[13], w[14], w[15]};
        le2 = {w[5], w[4], w[3], w[2]};
        le4 = {w[7], w[6], w[5], w[4]};
        le6 = {w[9], w[8], w[7], w[6]};
        le10 = {w[13], w[12], w[11], w[10]};
        ext = (be0 == 32'd1);
        box = ext ? {be8, be12} : {32'd0, be0};
        minimum = ext ? 64'd24 : 64'd16;
        bok = 1'b0;

        if (n >= 13'd2 && w[0] == 8'hFF && w[1] == 8'h0A) begin
            o_result = mk(rfs_pkg::FMT_JPEGXL, rfs_pkg::ST_MATCHED, 0);
        end else if (n >= 13'd4 && m_jxl) begin
            o_result = (n < 13'd12) ? mk(rfs_pkg::FMT_JPEGXL, rfs_pkg::ST_TRUNCATED, 12)
                                    : mk(rfs_pkg::FMT_JPEGXL, rfs_pkg::ST_MATCHED, 0);
        end else if (n >= 13'd1 && m_psd) begin
            o_result = (n < 13'd4) ? mk(rfs_pkg::FMT_PSD, rfs_pkg::ST_TRUNCATED, 4)
                                   : mk(rfs_pkg::FMT_PSD, rfs_pkg::ST_MATCHED, 0);
        end else if (m_jpg) begin
            if (n < 13'd3) begin
                o_result = mk((n >= 13'd2) ? rfs_pkg::FMT_JPEG : rfs_pkg::FMT_UNKNOWN,
                              rfs_pkg::ST_TRUNCATED, 3);
            end else begin
                o_result = mk(rfs_pkg::FMT_JPEG, rfs_pkg::ST_MATCHED, 0);
            end
        end else if (n >= 13'd2 && w[0] == 8'hFF && w[1] == 8'hD8) begin
            o_result = mk(rfs_pkg::FMT_JPEG, rfs_pkg::ST_MALFORMED, 0);
        end else if (m_png) begin
            o_result = (n < 13'd8) ? mk(rfs_pkg::FMT_PNG, rfs_pkg::ST_TRUNCATED, 8)
                                   : mk(rfs_pkg::FMT_PNG, rfs_pkg::ST_MATCHED, 0);
        end else if (n >= 13'd4 && w[0] == 8'h89 && w[1] == 8'h50 && w[2] == 8'h4E &&
                     w[3] == 8'h47) begin
            o_result = mk(rfs_pkg::FMT_PNG, rfs_pkg::ST_MALFORMED, 0);
        end else if (m_g7 || m_g9) begin
            o_result = (n < 13'd6) ? mk(rfs_pkg::FMT_GIF, rfs_pkg::ST_TRUNCATED, 6)
                                   : mk(rfs_pkg::FMT_GIF, rfs_pkg::ST_MATCHED, 0);
        end else if (n >= 13'd4 && w[0] == 8'h47 && w[1] == 8'h49 && w[2] == 8'h46 &&
                     w[3] == 8'h38) begin
            o_result = mk(rfs_pkg::FMT_GIF, rfs_pkg::ST_MALFORMED, 0);
        end else if (n == 13'd1 && w[0] == 8'h42) begin
            o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_TRUNCATED, 2);
        end else if (n >= 13'd2 && w[0] == 8'h42 && w[1] == 8'h4D) begin
            if (n < 13'd14) begin
                o_result = mk(rfs_pkg::FMT_BMP, rfs_pkg::ST_TRUNCATED, 14);
            end else if (le6 != 32'd0 || le10 < 32'd14 || (le2 != 32'd0 && le2 < le10)) begin
                o_result = mk(rfs_pkg::FMT_BMP, rfs_pkg::ST_MALFORMED, 0);
            end else begin
                o_result = mk(rfs_pkg::FMT_BMP, rfs_pkg::ST_MATCHED, 0);
            end
        end else if (m_ico) begin
            if (n < 13'd4) o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_TRUNCATED, 4);
            else if (n < 13'd6) o_result = mk(rfs_pkg::FMT_ICO, rfs_pkg::ST_TRUNCATED, 6);
            else if (w[4] == 8'h00 && w[5] == 8'h00)
                o_result = mk(rfs_pkg::FMT_ICO, rfs_pkg::ST_MALFORMED, 0);
            else o_result = mk(rfs_pkg::FMT_ICO, rfs_pkg::ST_MATCHED, 0);
        end else if (m_lc || m_bc || m_lb || m_bb) begin
            bok = (m_lb && w[4] == 8'h08 && w[5] == 8'h00 && w[6] == 8'h00 && w[7] == 8'h00) ||
                  (m_bb && w[4] == 8'h00 && w[5] == 8'h08 && w[6] == 8'h00 && w[7] == 8'h00);
            if (n < 13'd4) o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_TRUNCATED, 4);
            else if (m_lc || m_bc) o_result = mk(rfs_pkg::FMT_TIFF, rfs_pkg::ST_MATCHED, 0);
            else if (n < 13'd8) o_result = mk(rfs_pkg::FMT_TIFF, rfs_pkg::ST_TRUNCATED, 8);
            else o_result = mk(rfs_pkg::FMT_TIFF,
                               bok ? rfs_pkg::ST_MATCHED : rfs_pkg::ST_MALFORMED, 0);
        end else if (m_riff) begin
            if (n < 13'd4) o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_TRUNCATED, 4);
            else if (!m_webp) o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_UNSUPPORTED, 0);
            else if (n < 13'd12) o_result = mk(rfs_pkg::FMT_WEBP, rfs_pkg::ST_TRUNCATED, 12);
            else if (le4 < 32'd4 || le4[0])
                o_result = mk(rfs_pkg::FMT_WEBP, rfs_pkg::ST_MALFORMED, 0);
            else o_result = mk(rfs_pkg::FMT_WEBP, rfs_pkg::ST_MATCHED, 0);
        end else if (n < 13'd8) begin
            if (n > 13'd4 && m_ftyp4)
                o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_TRUNCATED, 8);
            else o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_UNSUPPORTED, 0);
        end else if (m_ftyp4) begin
            if (be0 == 32'd0) begin
                o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_MALFORMED, 0);
            end else if (ext && n < 13'd16) begin
                o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_TRUNCATED, 16);
            end else if (box < minimum || box > 64'(rfs_pkg::MaxProbeBytes) ||
                         box[1:0] != 2'b00) begin
                o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_MALFORMED, 0);
            end else if (64'(i_count) < box) begin
                o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_TRUNCATED, 32'(box[16:0]));
            end else if (rfs_pkg::brand_is_avif(i_major) || i_avif) begin
                o_result = mk(rfs_pkg::FMT_AVIF, (i_major == 32'h61766966 || i_still)
                              ? rfs_pkg::ST_MATCHED : rfs_pkg::ST_UNSUPPORTED, 0);
            end else if (rfs_pkg::brand_is_hevc(i_major) || i_hevc) begin
                o_result = mk(rfs_pkg::FMT_HEIF, rfs_pkg::ST_MATCHED, 0);
            end else begin
                o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_UNSUPPORTED, 0);
            end
        end else begin
            o_result = mk(rfs_pkg::FMT_UNKNOWN, rfs_pkg::ST_UNSUPPORTED, 0);
        end
    end
endmodule
`default_nettype wire

[rtl/raster_format_sniffer_unit.sv]
// Raster format sniffer top level: byte intake, brand tracking and result register.
// Depends on rfs_pkg, rfs_stream_if, rfs_classify and the defines header.
//
// Usage: the input channel carries one prefix byte per word with byte_valid and
// last flags; the output channel carries one word per prefix with format_code,
// probe_status and bytes_required. Each input word is registered first; the
// staged word then updates the header window, byte count and ftyp brand state,
// and on a last word classifies and loads the result register. A result is
// thus visible once its staged last word is loaded into the result register. One input word is
// taken every cycle; the only stall comes from a full result register whose
// word the receiver has not yet taken, and a staged last word then waits.
// Bytes beyond 4096 are dropped. Reset clears the count, brand state and the
// valid flags; the window needs no clearing since reads are gated by the count.
// A stalled receiver holds the result steady and backs up the input by one word.
`default_nettype none
`include "raster_format_sniffer_unit_defines.svh"
module raster_format_sniffer_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rfs_in_if.sink     i_in,
    rfs_out_if.source  o_out
);
    localparam int unsigned CW = rfs_pkg::CountW;

    logic             r_in_v, n_in_v;
    logic [7:0]       r_in_byte;
    logic             r_in_bv, r_in_last;
    logic [7:0]       r_win [16];
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_major, n_major, r_asm, n_asm;
    logic             r_hevc, n_hevc, r_avif, n_avif, r_still, n_still;
    logic             r_out_v, n_out_v;
    rfs_pkg::t_result r_out, cls;
    logic [7:0]       eff_win [16];
    logic             take, fire, stage_go, in_acc;
    logic [31:0]      be0, be8, be12;
    logic [63:0]      box;
    logic [CW-1:0]    off;
    logic [4:0]       hdr;

    // The staged word may retire unless it is a last word facing a full output that the receiver is not taking.
    assign fire     = r_in_v && r_in_last;
    assign stage_go = !r_in_v || !fire || !r_out_v || o_out.ready;
    assign i_in.ready = stage_go;
    assign in_acc   = i_in.valid && i_in.ready;
    assign take     = r_in_v && stage_go && r_in_bv && (r_count < CW'(rfs_pkg::MaxProbeBytes));

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            eff_win[i] = (take && r_count == CW'(i)) ? r_in_byte : r_win[i];
        end
    end

    always_comb begin
        be0  = {r_win[0], r_win[1], r_win[2], r_win[3]};
        be8  = {r_win[8], r_win[9], r_win[10], r_win[11]};
        be12 = {r_win[12], r_win[13], r_win[14], r_win[15]};
        box  = (be0 == 32'd1) ? {be8, be12} : {32'd0, be0};
        hdr  = (be0 == 32'd1) ? 5'd16 : 5'd8;
        off  = r_count - CW'(3);
        n_asm = r_asm;
        n_major = r_major;
        n_hevc = r_hevc;
        n_avif = r_avif;
        n_still = r_still;
        n_count = r_count;
        if (take) begin
            n_asm = {r_asm[23:0], r_in_byte};
            n_count = r_count + CW'(1);
            if (r_count >= CW'(11) && r_count[1:0] == 2'b11) begin
                if (off == CW'(hdr)) n_major = n_asm;
                if (off >= CW'(hdr) + CW'(8) && 64'(off) < box) begin
                    if (rfs_pkg::brand_is_hevc(n_asm)) n_hevc = 1'b1;
                    if (rfs_pkg::brand_is_avif(n_asm)) n_avif = 1'b1;
                    if (n_asm == 32'h61766966) n_still = 1'b1;
                end
            end
        end
    end

    rfs_classify u_classify (
        .i_win    (eff_win),
        .i_count  (n_count),
        .i_major  (n_major),
        .i_hevc   (n_hevc),
        .i_avif   (n_avif),
        .i_still  (n_still),
        .o_result (cls)
    );

    always_comb begin
        n_in_v = stage_go ? in_acc : r_in_v;
        n_out_v = r_out_v;
        if (o_out.ready) n_out_v = 1'b0;
        if (fire && stage_go) n_out_v = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_out_v <= 1'b0;
            r_count <= '0;
            r_major <= '0;
            r_asm <= '0;
            r_hevc <= 1'b0;
            r_avif <= 1'b0;
            r_still <= 1'b0;
        end else begin
            r_in_v <= n_in_v;
            r_out_v <= n_out_v;
            if (r_in_v && stage_go && fire) begin
                r_count <= '0;
                r_major <= '0;
                r_asm <= '0;
                r_hevc <= 1'b0;
                r_avif <= 1'b0;
                r_still <= 1'b0;
            end else begin
                r_count <= n_count;
                r_major <= n_major;
                r_asm <= n_asm;
                r_hevc <= n_hevc;
                r_avif <= n_avif;
                r_still <= n_still;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go) begin
            r_in_byte <= i_in.data_byte;
            r_in_bv <= i_in.byte_valid;
            r_in_last <= i_in.last;
        end
        if (take && r_count < CW'(16)) begin
            r_win[r_count[3:0]] <= r_in_byte;
        end
        if (fire && stage_go) begin
            r_out <= cls;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.format_code = r_out.format_code;
    assign o_out.probe_status = r_out.probe_status;
    assign o_out.bytes_required = r_out.bytes_required;

    `RFS_ASSERT_IMPL(a_count_limit, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(rfs_pkg::MaxProbeBytes), "byte count above limit")
    `RFS_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, r_out_v && !o_out.ready,
        r_out_v && $stable(r_out), "result changed while stalled")
    `RFS_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, fire && stage_go,
        r_count == '0 && !r_hevc && !r_avif && !r_still, "state not cleared after result")
    `RFS_ASSERT_IMPL(a_req_only_trunc, i_clk, i_rst_n,
        r_out_v && r_out.probe_status != rfs_pkg::ST_TRUNCATED,
        r_out.bytes_required == '0, "bytes required set on non-truncated result")
endmodule
`default_nettype wire
